// ----- hw/rtl/mts_pkg.sv -----
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned Width = 32;
  localparam int unsigned LvlW  = 7;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [Width-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [Width-1:0] top_value;
    logic signed [Width-1:0] min_value;
    logic [LvlW-1:0]         count;
    logic                    is_empty;
    logic                    op_error;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/min_tracking_stack.sv -----
// The result word of a command shows in the cycle after start is taken.
// Throughput: one command per cycle; every push or pop shifts the whole row of
// cells by one place at once, and busy never rises.
// Reset clears the level, the strobe and the error flag; stored words are undefined until pushed.
// The receiver cannot stall: each result is flagged by res_valid_o for one cycle only.
`timescale 1ns / 1ps

module min_tracking_stack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mts_pkg::cmd_t  cmd_i,
  output logic           res_valid_o,
  output mts_pkg::res_t  res_o
);

  mts_pkg::cell_ctl_t               ctl;
  logic signed [mts_pkg::Width-1:0] new_min;
  logic signed [mts_pkg::Width-1:0] word [mts_pkg::Depth];
  logic signed [mts_pkg::Width-1:0] mins [mts_pkg::Depth];

  assign busy = 1'b0;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .top_word_i  (word[0]),
    .top_min_i   (mins[0]),
    .ctl_o       (ctl),
    .new_min_o   (new_min),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  for (genvar i = 0; i < mts_pkg::Depth; i++) begin : g_cell
    logic signed [mts_pkg::Width-1:0] up_word, up_min, dn_word, dn_min;

    if (i == 0) begin : g_head
      assign up_word = cmd_i.value;
      assign up_min  = new_min;
    end else begin : g_body
      assign up_word = word[i-1];
      assign up_min  = mins[i-1];
    end

    if (i == mts_pkg::Depth - 1) begin : g_tail
      assign dn_word = '0;
      assign dn_min  = '0;
    end else begin : g_link
      assign dn_word = word[i+1];
      assign dn_min  = mins[i+1];
    end

    mts_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .up_word_i (up_word),
      .up_min_i  (up_min),
      .dn_word_i (dn_word),
      .dn_min_i  (dn_min),
      .word_o    (word[i]),
      .min_o     (mins[i])
    );
  end

endmodule

// ----- hw/rtl/mts_cell.sv -----
`timescale 1ns / 1ps

module mts_cell (
  input  logic                             clk_i,
  input  mts_pkg::cell_ctl_t               ctl_i,
  input  logic signed [mts_pkg::Width-1:0] up_word_i,
  input  logic signed [mts_pkg::Width-1:0] up_min_i,
  input  logic signed [mts_pkg::Width-1:0] dn_word_i,
  input  logic signed [mts_pkg::Width-1:0] dn_min_i,
  output logic signed [mts_pkg::Width-1:0] word_o,
  output logic signed [mts_pkg::Width-1:0] min_o
);

  logic signed [mts_pkg::Width-1:0] word_q, word_d;
  logic signed [mts_pkg::Width-1:0] min_q, min_d;

  always_comb begin
    word_d = word_q;
    min_d  = min_q;
    if (ctl_i.push) begin
      word_d = up_word_i;
      min_d  = up_min_i;
    end else if (ctl_i.pop) begin
      word_d = dn_word_i;
      min_d  = dn_min_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    min_q  <= min_d;
  end

  assign word_o = word_q;
  assign min_o  = min_q;

endmodule

// ----- hw/rtl/mts_ctrl.sv -----
`timescale 1ns / 1ps

module mts_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  mts_pkg::cmd_t                    cmd_i,
  input  logic signed [mts_pkg::Width-1:0] top_word_i,
  input  logic signed [mts_pkg::Width-1:0] top_min_i,
  output mts_pkg::cell_ctl_t               ctl_o,
  output logic signed [mts_pkg::Width-1:0] new_min_o,
  output logic                             res_valid_o,
  output mts_pkg::res_t                    res_o
);

  logic [mts_pkg::LvlW-1:0] level_q, level_d;
  logic                     valid_q, valid_d;
  logic                     err_q, err_d;
  logic                     full, empty;

  assign full  = (level_q == mts_pkg::LvlW'(mts_pkg::Depth));
  assign empty = (level_q == '0);

  always_comb begin
    ctl_o   = '0;
    err_d   = 1'b0;
    level_d = level_q;
    valid_d = start_i;
    if (start_i) begin
      case (cmd_i.mode)
        mts_pkg::MODE_PUSH: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            ctl_o.push = 1'b1;
            level_d    = level_q + 1'b1;
          end
        end
        mts_pkg::MODE_POP: begin
          if (empty) begin
            err_d = 1'b1;
          end else begin
            ctl_o.pop = 1'b1;
            level_d   = level_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // keep the running minimum below unless the new word is smaller
  assign new_min_o = (!empty && !(cmd_i.value < top_min_i)) ? top_min_i : cmd_i.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      valid_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      level_q <= level_d;
      valid_q <= valid_d;
      err_q   <= err_d;
    end
  end

  assign res_valid_o     = valid_q;
  assign res_o.top_value = empty ? '0 : top_word_i;
  assign res_o.min_value = empty ? '0 : top_min_i;
  assign res_o.count     = level_q;
  assign res_o.is_empty  = empty;
  assign res_o.op_error  = err_q;

endmodule
